// ----- sv/ipb_pkg.sv -----
// shared types, constants and tables for the isoelectric point bisection block
`default_nettype none
package ipb_pkg;

    localparam int PH_W      = 16;
    localparam int PH_FRAC   = 12;
    localparam int TERM_W    = 17;
    localparam int DIFF_W    = PH_W + 1;
    localparam int PREC_W    = 13;
    localparam int NUM_TERMS = 9;
    localparam int NUM_CNT   = 7;
    localparam int FRAC_STEPS = 12;
    localparam int DIV_STEPS  = 17;

    localparam logic [PREC_W-1:0] PREC_RESET = 13'd41;
    localparam logic [PH_W-1:0]   PH_START   = 16'd26624;
    localparam logic [PH_W-1:0]   PH_TOP     = 16'd57344;
    localparam logic [4:0]        ROUND_LAST = 5'd31;

    // pK per set in Q4.12, order: c-term, D, E, C, Y, H, n-term, K, R
    localparam logic [PH_W-1:0] PK_TAB [8][NUM_TERMS] = '{
        '{16'd14541, 16'd16589, 16'd17408, 16'd36864, 16'd40960,
          16'd24494, 16'd30720, 16'd40960, 16'd49152},
        '{16'd14746, 16'd15974, 16'd16794, 16'd34816, 16'd41370,
          16'd26624, 16'd35226, 16'd44237, 16'd51200},
        '{16'd12698, 16'd18022, 16'd18022, 16'd34816, 16'd40960,
          16'd26624, 16'd32768, 16'd40960, 16'd49152},
        '{16'd9830,  16'd15974, 16'd17613, 16'd33997, 16'd41370,
          16'd24576, 16'd39322, 16'd43008, 16'd51200},
        '{16'd13107, 16'd16384, 16'd18432, 16'd36864, 16'd40960,
          16'd26214, 16'd33587, 16'd42598, 16'd49152},
        '{16'd12698, 16'd15073, 16'd17408, 16'd34120, 16'd41247,
          16'd24576, 16'd32768, 16'd47104, 16'd47104},
        '{16'd17203, 16'd17203, 16'd17203, 16'd0,     16'd0,
          16'd0,     16'd45875, 16'd45875, 16'd45875},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    // 10^-k in Q1.32, k = 0..9
    localparam logic [32:0] POW_INT [10] = '{
        33'h1_0000_0000, 33'd429496730, 33'd42949673, 33'd4294967, 33'd429497,
        33'd42950, 33'd4295, 33'd429, 33'd43, 33'd4
    };

    // 10^-(2^-j) in Q0.32, j = 1..12
    localparam logic [31:0] POW_FRAC [FRAC_STEPS] = '{
        32'd1358187914, 32'd2415237601, 32'd3220771105, 32'd3719288448,
        32'd3996776482, 32'd4143190109, 32'd4218396145, 32'd4256509542,
        32'd4275695180, 32'd4285320404, 32'd4290141139, 32'd4292553539
    };

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] diff;
    } t_term_cmd;

endpackage
`default_nettype wire

// ----- sv/ipb_if.sv -----
// valid/ready channel interfaces for request, result and precision write
`default_nettype none
interface ipb_req_if #(parameter int COUNT_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [2:0]            req_type;
    logic [COUNT_BITS-1:0] count_asp;
    logic [COUNT_BITS-1:0] count_glu;
    logic [COUNT_BITS-1:0] count_cys;
    logic [COUNT_BITS-1:0] count_tyr;
    logic [COUNT_BITS-1:0] count_his;
    logic [COUNT_BITS-1:0] count_lys;
    logic [COUNT_BITS-1:0] count_arg;
    modport source (output valid, req_type, count_asp, count_glu, count_cys, count_tyr,
                    count_his, count_lys, count_arg, input ready);
    modport sink (input valid, req_type, count_asp, count_glu, count_cys, count_tyr,
                  count_his, count_lys, count_arg, output ready);
endinterface

interface ipb_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] isoelectric_ph;
    modport source (output valid, isoelectric_ph, input ready);
    modport sink (input valid, isoelectric_ph, output ready);
endinterface

interface ipb_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] precision;
    modport source (output valid, precision, input ready);
    modport sink (input valid, precision, output ready);
endinterface
`default_nettype wire

// ----- sv/isoelectric_point_bisection_top.sv -----
// top level: bisection sequencer around the shared charge term unit
// One request runs a pH bisection from 6.5 over 0..14; every round sums nine
// charge terms through a single term unit, each term taking 12 power steps and
// 17 divider steps besides start, load, scaling and done, followed in every
// round by the probe move and stop check. With the default precision a request
// finishes in 10 rounds, at most 32 rounds. The request channel is not ready
// from the accepted transfer until the result is handed to the output register
// in the output state after the last round; a result still waiting there only
// delays that handover. Precision is written through its own channel, always
// ready; write it only while the block is idle, which the block does not enforce.
`default_nettype none
module isoelectric_point_bisection_top #(
    parameter int COUNT_BITS = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ipb_req_if.sink       i_req,
    ipb_res_if.source     o_res,
    ipb_cfg_if.sink       i_cfg
);
    import ipb_pkg::*;

    localparam int PROD_W = COUNT_BITS + TERM_W;
    localparam int ACC_W  = COUNT_BITS + TERM_W + 4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TERM  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_CHECK = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]              r_type, n_type;
    logic [COUNT_BITS-1:0]   r_cnt [NUM_CNT];
    logic [PH_W-1:0]         r_probe, n_probe;
    logic [PH_W-1:0]         r_lower, n_lower;
    logic [PH_W-1:0]         r_upper, n_upper;
    logic signed [ACC_W-1:0] r_net, n_net;
    logic [3:0]              r_term, n_term;
    logic [4:0]              r_round, n_round;
    logic [PREC_W-1:0]       r_prec;
    logic                    r_res_valid;
    logic [PH_W-1:0]         r_res_ph;

    t_term_cmd               term_cmd;
    logic [COUNT_BITS-1:0]   term_count;
    logic                    term_done;
    logic [PROD_W-1:0]       term_prod;
    logic [PH_W-1:0]         pk;
    logic                    is_neg;
    logic signed [ACC_W-1:0] prod_ext;
    logic [PH_W-1:0]         gap_lo, gap_hi;
    logic                    req_take;
    logic                    res_load;

    assign pk     = PK_TAB[r_type][r_term];
    assign is_neg = r_term < 4'd5;
    assign term_cmd.start = (r_state == S_TERM);
    assign term_cmd.diff  = is_neg ? ({1'b0, pk} - {1'b0, r_probe})
                                   : ({1'b0, r_probe} - {1'b0, pk});

    always_comb begin
        case (r_term)
            4'd1:    term_count = r_cnt[0];
            4'd2:    term_count = r_cnt[1];
            4'd3:    term_count = r_cnt[2];
            4'd4:    term_count = r_cnt[3];
            4'd5:    term_count = r_cnt[4];
            4'd7:    term_count = r_cnt[5];
            4'd8:    term_count = r_cnt[6];
            default: term_count = COUNT_BITS'(1); // termini
        endcase
    end

    ipb_term #(.COUNT_BITS(COUNT_BITS)) u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (term_cmd),
        .i_count (term_count),
        .o_done  (term_done),
        .o_prod  (term_prod)
    );

    assign prod_ext = $signed({{(ACC_W-PROD_W){1'b0}}, term_prod});
    assign gap_lo   = r_probe - r_lower;
    assign gap_hi   = r_upper - r_probe;
    assign req_take = i_req.valid && i_req.ready;
    // output register free or emptied by a transfer this cycle
    assign res_load = (r_state == S_OUT) && (!r_res_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        n_type  = r_type;
        n_probe = r_probe;
        n_lower = r_lower;
        n_upper = r_upper;
        n_net   = r_net;
        n_term  = r_term;
        n_round = r_round;
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_type  = i_req.req_type;
                    n_probe = PH_START;
                    n_lower = '0;
                    n_upper = PH_TOP;
                    n_net   = '0;
                    n_term  = '0;
                    n_round = '0;
                    n_state = S_TERM;
                end
            end
            S_TERM: n_state = S_WAIT;
            S_WAIT: begin
                if (term_done) begin
                    n_net = is_neg ? (r_net - prod_ext) : (r_net + prod_ext);
                    if (r_term == 4'(NUM_TERMS - 1)) begin
                        n_state = S_MOVE;
                    end else begin
                        n_term  = r_term + 4'd1;
                        n_state = S_TERM;
                    end
                end
            end
            S_MOVE: begin
                if (r_net[ACC_W-1]) begin
                    n_probe = r_probe - (gap_lo >> 1);
                    n_upper = r_probe;
                end else begin
                    n_probe = r_probe + (gap_hi >> 1);
                    n_lower = r_probe;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if ((gap_lo < PH_W'(r_prec) && gap_hi < PH_W'(r_prec))
                    || r_round == ROUND_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_round = r_round + 5'd1;
                    n_term  = '0;
                    n_net   = '0;
                    n_state = S_TERM;
                end
            end
            S_OUT: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prec      <= PREC_RESET;
            r_probe     <= '0;
            r_lower     <= '0;
            r_upper     <= '0;
            r_net       <= '0;
            r_term      <= '0;
            r_round     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_probe <= n_probe;
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_net   <= n_net;
            r_term  <= n_term;
            r_round <= n_round;
            if (i_cfg.valid && i_cfg.ready) begin
                r_prec <= i_cfg.precision;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
        r_type <= n_type;
        if (res_load) begin
            r_res_ph <= r_probe;
        end
        if (req_take) begin
            r_cnt[0] <= i_req.count_asp;
            r_cnt[1] <= i_req.count_glu;
            r_cnt[2] <= i_req.count_cys;
            r_cnt[3] <= i_req.count_tyr;
            r_cnt[4] <= i_req.count_his;
            r_cnt[5] <= i_req.count_lys;
            r_cnt[6] <= i_req.count_arg;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_res_valid;
    assign o_res.isoelectric_ph = r_res_ph;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.isoelectric_ph)))
        else $error("pending result dropped or changed");

    a_ph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.isoelectric_ph <= PH_TOP)
        else $error("isoelectric point beyond pH 14");

    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lower <= r_probe && r_probe <= r_upper))
        else $error("probe left the bisection interval");

    a_start_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_probe == PH_START && r_round == 5'd0))
        else $error("bisection not restarted at pH 6.5");
endmodule
`default_nettype wire

// ----- sv/ipb_term.sv -----
// shared charge term unit: count * 1/(1+10^d) by power steps and a radix-2 divider
`default_nettype none
module ipb_term #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ipb_pkg::t_term_cmd                   i_cmd,
    input  logic [COUNT_BITS-1:0]                i_count,
    output logic                                 o_done,
    output logic [COUNT_BITS+ipb_pkg::TERM_W-1:0] o_prod
);
    import ipb_pkg::*;

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_POW   = 5'b00010,
        T_PREP  = 5'b00100,
        T_DIV   = 5'b01000,
        T_SCALE = 5'b10000
    } t_tstate;

    t_tstate r_state, n_state;
    logic [32:0]        r_x, n_x;
    logic [11:0]        r_fr, n_fr;
    logic               r_dpos, n_dpos;
    logic [4:0]         r_step, n_step;
    logic [33:0]        r_den, n_den;
    logic [33:0]        r_rem, n_rem;
    logic [TERM_W-1:0]  r_q, n_q;
    logic [COUNT_BITS+TERM_W-1:0] r_prod, n_prod;
    logic               r_done, n_done;

    logic [DIFF_W-1:0]  mag_w;
    logic [PH_W-1:0]    mag;
    logic [3:0]         k;
    logic [3:0]         fidx;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [33:0]        den;
    logic [48:0]        num, nsum;
    logic [34:0]        trial;
    logic               ge;

    assign mag_w = i_cmd.diff[DIFF_W-1] ? (~i_cmd.diff + 1'b1) : i_cmd.diff;
    assign mag   = mag_w[PH_W-1:0];
    assign k     = mag[PH_W-1:PH_FRAC];
    assign fidx  = (r_step < 5'(FRAC_STEPS)) ? r_step[3:0] : 4'd0;

    // one multiplier serves both the power steps and the final count scaling
    assign mul_a = (r_state == T_SCALE) ? 32'(i_count) : r_x[31:0];
    assign mul_b = (r_state == T_SCALE) ? 32'(r_q) : POW_FRAC[fidx];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign den   = 34'h1_0000_0000 + 34'(r_x);
    assign num   = r_dpos ? {r_x, 16'd0} : 49'h1_0000_0000_0000;
    assign nsum  = num + 49'(den[33:1]);
    assign trial = {r_rem, r_q[TERM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_fr    = r_fr;
        n_dpos  = r_dpos;
        n_step  = r_step;
        n_den   = r_den;
        n_rem   = r_rem;
        n_q     = r_q;
        n_prod  = r_prod;
        n_done  = 1'b0;
        case (r_state)
            T_IDLE: begin
                if (i_cmd.start) begin
                    n_x     = (k >= 4'd10) ? 33'd0 : POW_INT[k];
                    n_fr    = mag[PH_FRAC-1:0];
                    n_dpos  = !i_cmd.diff[DIFF_W-1];
                    n_step  = '0;
                    n_state = T_POW;
                end
            end
            T_POW: begin
                if (r_fr[11]) begin
                    // x of exactly one times the factor is the factor itself
                    n_x = r_x[32] ? {1'b0, POW_FRAC[fidx]} : {1'b0, mul_p[63:32]};
                end
                n_fr = {r_fr[10:0], 1'b0};
                if (r_step == 5'(FRAC_STEPS - 1)) begin
                    n_state = T_PREP;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            T_PREP: begin
                n_den   = den;
                n_rem   = {2'b00, nsum[48:17]};
                n_q     = nsum[16:0];
                n_step  = '0;
                n_state = T_DIV;
            end
            T_DIV: begin
                n_rem = ge ? 34'(trial - {1'b0, r_den}) : trial[33:0];
                n_q   = {r_q[TERM_W-2:0], ge};
                if (r_step == 5'(DIV_STEPS - 1)) begin
                    n_state = T_SCALE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            T_SCALE: begin
                n_prod  = mul_p[COUNT_BITS+TERM_W-1:0];
                n_done  = 1'b1;
                n_state = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_step  <= n_step;
        end
        r_x    <= n_x;
        r_fr   <= n_fr;
        r_dpos <= n_dpos;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule
`default_nettype wire
